### src/amsc_pkg.sv
// ----------------------------------------------------------------------------
// Alarm controller package
// Shared types, constants and the 12-hour to minutes-of-day conversion.
// ----------------------------------------------------------------------------
package amsc_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [4:0]  DIAL_HOURS   = 5'd12;
   localparam logic [10:0] HOUR_MINUTES = 11'd60;
   localparam logic [11:0] DAY_MINUTES  = 12'd1440;
   localparam logic [11:0] TWO_DAYS     = 12'd2880;

   localparam logic [3:0]  ALARM_HOUR_RESET      = 4'd7;
   localparam logic [5:0]  ALARM_MINUTE_RESET    = 6'd0;
   localparam logic        ALARM_AFTERNOON_RESET = 1'b0;
   localparam logic [10:0] SNOOZE_LENGTH_RESET   = 11'd9;

   typedef enum logic [1:0] {
      OP_CHECK      = 2'd0,
      OP_SNOOZE     = 2'd1,
      OP_DISMISS    = 2'd2,
      OP_SET_ENABLE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_ALARM_HOUR      = 2'd0,
      REG_ALARM_MINUTE    = 2'd1,
      REG_ALARM_AFTERNOON = 2'd2,
      REG_SNOOZE_LENGTH   = 2'd3
   } reg_index_type;

   typedef struct packed {
      op_type     operation;
      logic [3:0] now_hour;
      logic [5:0] now_minute;
      logic       now_afternoon;
      logic       enable_value;
   } req_type;

   typedef struct packed {
      logic [3:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic        alarm_afternoon;
      logic [10:0] snooze_length;
   } cfg_type;

   typedef struct packed {
      logic ringing_flag;
      logic snoozed_flag;
      logic enabled_flag;
   } flags_type;

   function automatic logic [10:0] minutes_of_day(logic [3:0] hour, logic [5:0] minute,
                                                  logic pm);
      logic [4:0]  h;
      logic [10:0] hw;
      h = {1'b0, hour};
      if (h >= DIAL_HOURS) begin
         h = h - DIAL_HOURS;
      end
      if (pm) begin
         h = h + DIAL_HOURS;
      end
      hw = {6'b0, h};
      return 11'(hw * HOUR_MINUTES) + {5'b0, minute};
   endfunction

endpackage

### src/amsc_if.sv
// ----------------------------------------------------------------------------
// Alarm controller channels
// Valid/ready channels for requests and for result flags.
// ----------------------------------------------------------------------------
interface amsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [3:0] now_hour;
   logic [5:0] now_minute;
   logic       now_afternoon;
   logic       enable_value;

   modport source (output valid, operation, now_hour, now_minute, now_afternoon,
                   enable_value, input ready);
   modport sink (input valid, operation, now_hour, now_minute, now_afternoon,
                 enable_value, output ready);
endinterface

interface amsc_rsp_if;
   logic valid;
   logic ready;
   logic ringing_flag;
   logic snoozed_flag;
   logic enabled_flag;

   modport source (output valid, ringing_flag, snoozed_flag, enabled_flag, input ready);
   modport sink (input valid, ringing_flag, snoozed_flag, enabled_flag, output ready);
endinterface

### src/alarm_match_snooze_controller_top.sv
// ----------------------------------------------------------------------------
// Alarm match and snooze controller
// Flow: an accepted request waits in the input register; its flags are held
// in the result register. Throughput: one request per cycle while rsp_bus is
// ready; while it stalls, the input register still takes one if it is empty.
// Reset is synchronous and active high, clears the channels and all alarm
// state, and loads the register defaults: 7:00 AM alarm, nine-minute snooze.
// ----------------------------------------------------------------------------
module alarm_match_snooze_controller_top (
   input  logic                                 clock,
   input  logic                                 reset,
   amsc_req_if.sink                             req_bus,
   amsc_rsp_if.source                           rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [amsc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [amsc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [amsc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   amsc_pkg::cfg_type   cfg;
   amsc_pkg::flags_type flags;
   amsc_pkg::req_type   in_req_ff;
   amsc_pkg::flags_type out_flags_ff;
   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance;
   logic                step;
   logic                accept;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   amsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   amsc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_req_ff),
      .cfg   (cfg),
      .flags (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff.operation     <= amsc_pkg::op_type'(req_bus.operation);
         in_req_ff.now_hour      <= req_bus.now_hour;
         in_req_ff.now_minute    <= req_bus.now_minute;
         in_req_ff.now_afternoon <= req_bus.now_afternoon;
         in_req_ff.enable_value  <= req_bus.enable_value;
      end
      if (step) begin
         out_flags_ff <= flags;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.ringing_flag = out_flags_ff.ringing_flag;
   assign rsp_bus.snoozed_flag = out_flags_ff.snoozed_flag;
   assign rsp_bus.enabled_flag = out_flags_ff.enabled_flag;

endmodule

### src/amsc_csr.sv
// ----------------------------------------------------------------------------
// Alarm controller registers
// APB-style register file holding the alarm time and the snooze length.
// ----------------------------------------------------------------------------
module amsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [amsc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [amsc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [amsc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output amsc_pkg::cfg_type                    cfg
);

   amsc_pkg::cfg_type       cfg_ff;
   amsc_pkg::cfg_type       cfg_in;
   amsc_pkg::reg_index_type index;
   logic                    write_en;

   assign index      = amsc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            amsc_pkg::REG_ALARM_HOUR:      cfg_in.alarm_hour      = csr_pwdata[3:0];
            amsc_pkg::REG_ALARM_MINUTE:    cfg_in.alarm_minute    = csr_pwdata[5:0];
            amsc_pkg::REG_ALARM_AFTERNOON: cfg_in.alarm_afternoon = csr_pwdata[0];
            amsc_pkg::REG_SNOOZE_LENGTH:   cfg_in.snooze_length   = csr_pwdata[10:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         amsc_pkg::REG_ALARM_HOUR:      csr_prdata = {28'b0, cfg_ff.alarm_hour};
         amsc_pkg::REG_ALARM_MINUTE:    csr_prdata = {26'b0, cfg_ff.alarm_minute};
         amsc_pkg::REG_ALARM_AFTERNOON: csr_prdata = {31'b0, cfg_ff.alarm_afternoon};
         amsc_pkg::REG_SNOOZE_LENGTH:   csr_prdata = {21'b0, cfg_ff.snooze_length};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_hour      <= amsc_pkg::ALARM_HOUR_RESET;
         cfg_ff.alarm_minute    <= amsc_pkg::ALARM_MINUTE_RESET;
         cfg_ff.alarm_afternoon <= amsc_pkg::ALARM_AFTERNOON_RESET;
         cfg_ff.snooze_length   <= amsc_pkg::SNOOZE_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/amsc_core.sv
// ----------------------------------------------------------------------------
// Alarm controller core
// Alarm state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module amsc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  amsc_pkg::req_type   req,
   input  amsc_pkg::cfg_type   cfg,
   output amsc_pkg::flags_type flags
);

   logic        armed_ff, armed_in;
   logic        ring_ff, ring_in;
   logic        snoozing_ff, snoozing_in;
   logic        matched_ff, matched_in;
   logic [10:0] target_ff, target_in;

   logic [10:0] now_minutes;
   logic [10:0] alarm_minutes;
   logic        hit;
   logic [11:0] sum;
   logic [11:0] wrapped;

   assign now_minutes   = amsc_pkg::minutes_of_day(req.now_hour, req.now_minute,
                                                   req.now_afternoon);
   assign alarm_minutes = amsc_pkg::minutes_of_day(cfg.alarm_hour, cfg.alarm_minute,
                                                   cfg.alarm_afternoon);
   assign hit = (now_minutes == alarm_minutes);
   assign sum = {1'b0, now_minutes} + {1'b0, cfg.snooze_length};

   always_comb begin
      if (sum >= amsc_pkg::TWO_DAYS) begin
         wrapped = sum - amsc_pkg::TWO_DAYS;
      end else if (sum >= amsc_pkg::DAY_MINUTES) begin
         wrapped = sum - amsc_pkg::DAY_MINUTES;
      end else begin
         wrapped = sum;
      end
   end

   always_comb begin
      armed_in    = armed_ff;
      ring_in     = ring_ff;
      snoozing_in = snoozing_ff;
      matched_in  = matched_ff;
      target_in   = target_ff;
      if (step) begin
         case (req.operation)
            amsc_pkg::OP_CHECK: begin
               if (snoozing_ff) begin
                  if (now_minutes == target_ff) begin
                     snoozing_in = 1'b0;
                     ring_in     = 1'b1;
                  end
               end else if (!armed_ff) begin
                  matched_in = 1'b0;
               end else begin
                  if (hit && !matched_ff) begin
                     ring_in = 1'b1;
                  end
                  matched_in = hit;
               end
            end
            amsc_pkg::OP_SNOOZE: begin
               if (ring_ff) begin
                  ring_in     = 1'b0;
                  snoozing_in = 1'b1;
                  target_in   = wrapped[10:0];
               end
            end
            amsc_pkg::OP_DISMISS: begin
               ring_in = 1'b0;
            end
            default: begin
               armed_in = req.enable_value;
               if (!req.enable_value) begin
                  ring_in = 1'b0;
               end
            end
         endcase
      end
   end

   assign flags.ringing_flag = ring_in;
   assign flags.snoozed_flag = snoozing_in;
   assign flags.enabled_flag = armed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= 1'b0;
         ring_ff     <= 1'b0;
         snoozing_ff <= 1'b0;
         matched_ff  <= 1'b0;
         target_ff   <= '0;
      end else begin
         armed_ff    <= armed_in;
         ring_ff     <= ring_in;
         snoozing_ff <= snoozing_in;
         matched_ff  <= matched_in;
         target_ff   <= target_in;
      end
   end

`ifndef SYNTHESIS
   a_ring_excludes_snooze: assert property (@(posedge clock) disable iff (reset)
      !(ring_ff && snoozing_ff))
      else $error("Ringing and snoozing are both set.");

   a_target_in_day: assert property (@(posedge clock) disable iff (reset)
      {1'b0, target_ff} < amsc_pkg::DAY_MINUTES)
      else $error("Snooze target is outside the day.");

   a_dismiss_silences: assert property (@(posedge clock) disable iff (reset)
      step && req.operation == amsc_pkg::OP_DISMISS |=> !ring_ff)
      else $error("Dismiss did not stop the ring.");

   a_enable_follows: assert property (@(posedge clock) disable iff (reset)
      step && req.operation == amsc_pkg::OP_SET_ENABLE
      |=> armed_ff == $past(req.enable_value))
      else $error("Enable flag does not follow the request.");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(ring_ff) && $stable(snoozing_ff) && $stable(target_ff))
      else $error("Alarm state changed without a request.");
`endif

endmodule
